### rtl/core/edfrt_pkg.sv
package edfrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int ORDER_BITS  = 8;
   localparam int TICK_BITS   = 32;

   localparam logic FUNC_RELEASE  = 1'b0;
   localparam logic FUNC_COMPLETE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STATUS_STORED    = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_REMOVED   = 2'd2,
      STATUS_UNMATCHED = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [TICK_BITS-1:0]  deadline;
      logic [TICK_BITS-1:0]  release_tick;
      logic [ORDER_BITS-1:0] order;
   } entry_type;

endpackage

### rtl/core/edf_ready_table_top.sv
// Earliest-deadline-first ready table.
// Request channel (req_valid/req_ready): req_func selects a release, which
// stores task id, deadline and req_now as release tick, or a completion, which
// removes the earliest-deadline task if its id matches req_task_id.
// Response channel (rsp_valid/rsp_ready): exactly one item per request, with
// the status, the earliest-deadline task after the event, lateness and
// release tick of a removed task, and the number of active tasks.
// Task entries live in a single-port-write, registered-read memory; valid
// bits are flip-flops. After every change of the table the block scans all
// entries through the memory read port to find the new earliest task, one
// entry per cycle, before a stored release or a removing completion is
// answered. A dropped release or an unmatched completion changes nothing and
// is answered from the idle state without a scan.
// A new request is taken only in the idle state and only when the response
// register is empty or being emptied in the same cycle; a stalled receiver
// therefore holds off further requests. Reset clears all valid bits, the
// release order counter and both handshakes; no clearing pass is needed.
module edf_ready_table_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [7:0]                 req_task_id,
   input  logic [31:0]                req_deadline,
   input  logic [31:0]                req_now,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_run_valid,
   output logic [7:0]                 rsp_run_task_id,
   output logic [31:0]                rsp_run_deadline,
   output logic                       rsp_done_late,
   output logic [31:0]                rsp_done_release_time,
   output logic [4:0]                 rsp_active_count
);
   import edfrt_pkg::*;

   state_type                state_ff, state_in;
   logic [TABLE_DEPTH-1:0]   valid_ff, valid_in;
   logic [ORDER_BITS-1:0]    order_ff, order_in;
   logic [IDX_BITS:0]        scan_cnt_ff, scan_cnt_in;
   logic                     pend_ff, pend_in;
   logic [IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;

   logic                     best_valid_ff, best_valid_in;
   logic [IDX_BITS-1:0]      best_idx_ff, best_idx_in;
   logic [ID_BITS-1:0]       best_id_ff, best_id_in;
   logic [TICK_BITS-1:0]     best_dl_ff, best_dl_in;
   logic [TICK_BITS-1:0]     best_rel_ff, best_rel_in;
   logic [ORDER_BITS-1:0]    best_age_ff, best_age_in;

   status_type               ev_status_ff, ev_status_in;
   logic                     ev_late_ff, ev_late_in;
   logic [TICK_BITS-1:0]     ev_rel_ff, ev_rel_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_run_valid_ff, rsp_run_valid_in;
   logic [7:0]               rsp_run_id_ff, rsp_run_id_in;
   logic [31:0]              rsp_run_dl_ff, rsp_run_dl_in;
   logic                     rsp_late_ff, rsp_late_in;
   logic [31:0]              rsp_rel_ff, rsp_rel_in;
   logic [4:0]               rsp_count_ff, rsp_count_in;

   entry_type                mem [TABLE_DEPTH];
   entry_type                rd_data_ff;
   entry_type                wr_entry;
   logic                     mem_wr;
   logic [IDX_BITS-1:0]      rd_addr;

   logic                     accept;
   logic [ID_BITS-1:0]       id_in;
   logic                     free_found;
   logic [IDX_BITS-1:0]      free_idx;
   logic [CNT_BITS-1:0]      valid_count;
   logic                     match;
   logic [ORDER_BITS-1:0]    cand_age;
   logic                     cand_better;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign id_in     = ID_BITS'(req_task_id);
   assign match     = best_valid_ff && (best_id_ff == id_in);
   assign rd_addr   = scan_cnt_ff[IDX_BITS-1:0];

   assign wr_entry.id           = id_in;
   assign wr_entry.deadline     = req_deadline;
   assign wr_entry.release_tick = req_now;
   assign wr_entry.order        = order_ff;

   assign cand_age    = order_ff - rd_data_ff.order;
   assign cand_better = !best_valid_ff || (rd_data_ff.deadline < best_dl_ff) ||
                        ((rd_data_ff.deadline == best_dl_ff) && (cand_age < best_age_ff));

   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      valid_count = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid_count = valid_count + CNT_BITS'(valid_ff[i]);
      end
   end

   always_comb begin
      state_in         = state_ff;
      valid_in         = valid_ff;
      order_in         = order_ff;
      scan_cnt_in      = scan_cnt_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      best_valid_in    = best_valid_ff;
      best_idx_in      = best_idx_ff;
      best_id_in       = best_id_ff;
      best_dl_in       = best_dl_ff;
      best_rel_in      = best_rel_ff;
      best_age_in      = best_age_ff;
      ev_status_in     = ev_status_ff;
      ev_late_in       = ev_late_ff;
      ev_rel_in        = ev_rel_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_run_valid_in = rsp_run_valid_ff;
      rsp_run_id_in    = rsp_run_id_ff;
      rsp_run_dl_in    = rsp_run_dl_ff;
      rsp_late_in      = rsp_late_ff;
      rsp_rel_in       = rsp_rel_ff;
      rsp_count_in     = rsp_count_ff;
      mem_wr           = 1'b0;

      // Entries read during the scan are compared in the cycle after their read.
      if (pend_ff && valid_ff[pend_idx_ff] && cand_better) begin
         best_valid_in = 1'b1;
         best_idx_in   = pend_idx_ff;
         best_id_in    = rd_data_ff.id;
         best_dl_in    = rd_data_ff.deadline;
         best_rel_in   = rd_data_ff.release_tick;
         best_age_in   = cand_age;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_RELEASE && free_found) begin
                  valid_in[free_idx] = 1'b1;
                  mem_wr             = 1'b1;
                  order_in           = order_ff + 1'b1;
                  ev_status_in       = STATUS_STORED;
                  ev_late_in         = 1'b0;
                  ev_rel_in          = '0;
                  state_in           = ST_SCAN;
               end else if (req_func == FUNC_COMPLETE && match) begin
                  valid_in[best_idx_ff] = 1'b0;
                  ev_status_in          = STATUS_REMOVED;
                  ev_late_in            = req_now > best_dl_ff;
                  ev_rel_in             = best_rel_ff;
                  state_in              = ST_SCAN;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = (req_func == FUNC_RELEASE) ? STATUS_FULL
                                                                : STATUS_UNMATCHED;
                  rsp_run_valid_in = best_valid_ff;
                  rsp_run_id_in    = best_valid_ff ? 8'(best_id_ff) : 8'd0;
                  rsp_run_dl_in    = best_valid_ff ? best_dl_ff : 32'd0;
                  rsp_late_in      = 1'b0;
                  rsp_rel_in       = 32'd0;
                  rsp_count_in     = 5'(valid_count);
               end
               scan_cnt_in   = '0;
               pend_in       = 1'b0;
               best_valid_in = 1'b0;
               if (state_in == ST_IDLE) begin
                  best_valid_in = best_valid_ff;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff != (IDX_BITS + 1)'(TABLE_DEPTH)) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = ev_status_ff;
            rsp_run_valid_in = best_valid_ff;
            rsp_run_id_in    = best_valid_ff ? 8'(best_id_ff) : 8'd0;
            rsp_run_dl_in    = best_valid_ff ? best_dl_ff : 32'd0;
            rsp_late_in      = ev_late_ff;
            rsp_rel_in       = ev_rel_ff;
            rsp_count_in     = 5'(valid_count);
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[free_idx] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         order_ff      <= '0;
         pend_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         order_ff      <= order_in;
         pend_ff       <= pend_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff      <= scan_cnt_in;
      pend_idx_ff      <= pend_idx_in;
      best_idx_ff      <= best_idx_in;
      best_id_ff       <= best_id_in;
      best_dl_ff       <= best_dl_in;
      best_rel_ff      <= best_rel_in;
      best_age_ff      <= best_age_in;
      ev_status_ff     <= ev_status_in;
      ev_late_ff       <= ev_late_in;
      ev_rel_ff        <= ev_rel_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_run_valid_ff <= rsp_run_valid_in;
      rsp_run_id_ff    <= rsp_run_id_in;
      rsp_run_dl_ff    <= rsp_run_dl_in;
      rsp_late_ff      <= rsp_late_in;
      rsp_rel_ff       <= rsp_rel_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_run_valid         = rsp_run_valid_ff;
   assign rsp_run_task_id       = rsp_run_id_ff;
   assign rsp_run_deadline      = rsp_run_dl_ff;
   assign rsp_done_late         = rsp_late_ff;
   assign rsp_done_release_time = rsp_rel_ff;
   assign rsp_active_count      = rsp_count_ff;

endmodule
